[rtl/hcbd_pkg.sv]
// ----------------------------------------------------------------------------
// HTTP chunked body deframer package
// Shared constants, status codes and the hex digit decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    localparam int DEFAULT_MAX_HEX_DIGITS = 8;
    localparam int SIZE_W                 = 32;

    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] CHAR_X_LOWER = 8'h78;
    localparam logic [7:0] CHAR_X_UPPER = 8'h58;

    typedef enum logic [1:0] {
        STATUS_FRAME   = 2'd0,
        STATUS_PAYLOAD = 2'd1,
        STATUS_LAST    = 2'd2,
        STATUS_ERROR   = 2'd3
    } byte_status_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t r;
        r.is_hex = 1'b0;
        r.value  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.is_hex = 1'b1;
            r.value  = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            // Both letter ranges keep the digit offset in the low three bits.
            r.is_hex = 1'b1;
            r.value  = 4'(c[2:0] + 3'd1) + 4'd8;
        end
        return r;
    endfunction

endpackage

[rtl/http_chunked_body_deframer_unit.sv]
// ----------------------------------------------------------------------------
// HTTP chunked body deframer
// Labels each byte of a chunked HTTP/1.1 body as framing, payload, end of
// body or error, and passes the byte through.
// ----------------------------------------------------------------------------
//  Channel   Direction  Ports                                   Meaning
//  input     in         s_valid s_ready s_data_in               one body byte
//  result    out        m_valid m_ready m_data_out m_byte_status byte and label
//
//  One byte is accepted every cycle while s_ready is high; an accepted byte
//  passes through the input register, then the result register, and is
//  presented on the result channel from the result register.
//  The parser state, digit count and chunk counter update as a byte moves
//  from the input register to the result register.
//  Reset (aresetn low, synchronous) empties both registers and returns the
//  parser to expecting the first size digit. A stalled result channel holds
//  the result and, once the input register is also full, drops s_ready.
// ----------------------------------------------------------------------------
module http_chunked_body_deframer_unit #(
    parameter int MAX_HEX_DIGITS = hcbd_pkg::DEFAULT_MAX_HEX_DIGITS
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data_out,
    output logic [1:0] m_byte_status
);
    import hcbd_pkg::*;

    localparam int CNT_W = $clog2(MAX_HEX_DIGITS + 1);

    typedef enum logic [3:0] {
        ST_START,
        ST_HEX,
        ST_HEX_LF,
        ST_DATA,
        ST_DATA_CR,
        ST_DATA_LF,
        ST_END_CR,
        ST_END_LF,
        ST_ERROR
    } parse_state_t;

    parse_state_t        state_reg, state_next;
    logic [CNT_W-1:0]    digit_count_reg, digit_count_next;
    logic [SIZE_W-1:0]   chunk_reg, chunk_next;
    logic                in_valid_reg;
    logic [7:0]          in_data_reg;
    logic                out_valid_reg;
    logic [7:0]          out_data_reg;
    byte_status_t        out_status_reg, status_next;

    logic                advance;
    logic                bad;
    logic                digit_ok;
    hex_digit_t          hex;
    logic [SIZE_W-1:0]   chunk_dec;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign m_valid       = out_valid_reg;
    assign m_data_out    = out_data_reg;
    assign m_byte_status = out_status_reg;

    assign hex       = hex_decode(in_data_reg);
    assign digit_ok  = (digit_count_reg < CNT_W'(MAX_HEX_DIGITS))
                       && (chunk_reg[SIZE_W-1 -: 4] == 4'd0);
    assign chunk_dec = chunk_reg - SIZE_W'(1);

    always_comb begin
        state_next       = state_reg;
        digit_count_next = digit_count_reg;
        chunk_next       = chunk_reg;
        status_next      = STATUS_FRAME;
        bad              = 1'b0;
        unique case (state_reg)
            ST_START: begin
                // The count and size restart at zero, so a first digit always fits.
                if (hex.is_hex) begin
                    digit_count_next = CNT_W'(1);
                    chunk_next       = SIZE_W'(hex.value);
                    state_next       = ST_HEX;
                end else begin
                    bad = 1'b1;
                end
            end
            ST_HEX: begin
                if (hex.is_hex) begin
                    if (digit_ok) begin
                        digit_count_next = digit_count_reg + CNT_W'(1);
                        chunk_next       = {chunk_reg[SIZE_W-5:0], hex.value};
                    end else begin
                        bad = 1'b1;
                    end
                end else if (in_data_reg == CHAR_X_LOWER || in_data_reg == CHAR_X_UPPER) begin
                    state_next = ST_HEX;
                end else if (in_data_reg == CHAR_CR) begin
                    state_next = ST_HEX_LF;
                end else begin
                    bad = 1'b1;
                end
            end
            ST_HEX_LF: begin
                if (in_data_reg == CHAR_LF) begin
                    digit_count_next = '0;
                    state_next = (chunk_reg == '0) ? ST_END_CR : ST_DATA;
                end else begin
                    bad = 1'b1;
                end
            end
            ST_DATA: begin
                status_next = STATUS_PAYLOAD;
                if (chunk_reg != '0) begin
                    chunk_next = chunk_dec;
                end
                if (chunk_reg == '0 || chunk_dec == '0) begin
                    state_next = ST_DATA_CR;
                end
            end
            ST_DATA_CR: begin
                if (in_data_reg == CHAR_CR) state_next = ST_DATA_LF;
                else                        bad = 1'b1;
            end
            ST_DATA_LF: begin
                if (in_data_reg == CHAR_LF) state_next = ST_START;
                else                        bad = 1'b1;
            end
            ST_END_CR: begin
                if (in_data_reg == CHAR_CR) state_next = ST_END_LF;
                else                        bad = 1'b1;
            end
            ST_END_LF: begin
                if (in_data_reg == CHAR_LF) begin
                    status_next = STATUS_LAST;
                    state_next  = ST_START;
                end else begin
                    bad = 1'b1;
                end
            end
            default: begin
                bad = 1'b1;
            end
        endcase
        if (bad) begin
            state_next  = ST_ERROR;
            status_next = STATUS_ERROR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_START;
            digit_count_reg <= '0;
            chunk_reg       <= '0;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_data_reg <= s_data_in;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                state_reg       <= state_next;
                digit_count_reg <= digit_count_next;
                chunk_reg       <= chunk_next;
                out_data_reg    <= in_data_reg;
                out_status_reg  <= status_next;
                out_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The end-of-body label only ever marks the LF of the final line.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_byte_status == STATUS_LAST) |-> (m_data_out == CHAR_LF))
        else $error("end-of-body status on a byte other than LF");

    // Once the parser has failed, only reset takes it out of the error state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ERROR) |=> (state_reg == ST_ERROR))
        else $error("parser left the error state without reset");

    // The size line never holds more digits than allowed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        digit_count_reg <= CNT_W'(MAX_HEX_DIGITS))
        else $error("hex digit count above its limit");

    // A payload label is produced only while a chunk still has bytes left.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && state_reg == ST_DATA) |-> (chunk_reg != '0))
        else $error("payload byte with an empty chunk counter");

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// Testbench for the HTTP chunked body deframer
// Drives chunked bodies byte by byte through the valid/ready input channel.
// A software parser runs beside the block and predicts the passed-through byte
// and its framing/payload/end/error label. Every result transaction is checked
// against that prediction. The sender and the receiver idle at several rates,
// and a long receiver hold-off fills the block. The last test breaks the
// framing on purpose, because an error stays until reset.
// ----------------------------------------------------------------------------
module tb_top;
    import hcbd_pkg::*;

    localparam int SIZE_DIGITS_MAX = DEFAULT_MAX_HEX_DIGITS;
    localparam int LIMIT_CYCLES    = 400000;

    typedef enum logic [3:0] {
        P_START,
        P_SIZE,
        P_SIZE_LF,
        P_DATA,
        P_DATA_CR,
        P_DATA_LF,
        P_END_CR,
        P_END_LF,
        P_ERROR
    } parser_state_t;

    typedef struct packed {
        logic [7:0]   data;
        byte_status_t status;
    } labeled_byte_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_in = 8'h00;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic [7:0] m_data_out;
    logic [1:0] m_byte_status;

    // Parser copy that tracks the block.
    parser_state_t parser_state = P_START;
    int            size_digits  = 0;
    logic [31:0]   chunk_left   = '0;

    labeled_byte_t labeled_bytes[$];
    labeled_byte_t want;
    int            mismatches    = 0;
    int            bytes_sent    = 0;
    int            cycle_count   = 0;
    int            tx_idle_pct   = 0;
    int            rx_stall_pct  = 0;
    int            hold_request  = 0;
    int            hold_left     = 0;

    http_chunked_body_deframer_unit #(
        .MAX_HEX_DIGITS(SIZE_DIGITS_MAX)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_in    (s_data_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data_out   (m_data_out),
        .m_byte_status(m_byte_status)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Returns 0 when the digit would exceed the digit limit or push a nonzero
    // nibble out of the 32-bit size.
    function automatic logic absorb_digit(input int nib);
        if (size_digits + 1 > SIZE_DIGITS_MAX) return 1'b0;
        if (chunk_left[31:28] != 4'd0) return 1'b0;
        chunk_left  = {chunk_left[27:0], 4'(nib)};
        size_digits = size_digits + 1;
        return 1'b1;
    endfunction

    function automatic byte_status_t predict_label(input logic [7:0] c);
        int           nib;
        byte_status_t lbl;
        logic         bad;
        nib = -1;
        if (c >= "0" && c <= "9") nib = int'(c) - int'(8'h30);
        else if (c >= "a" && c <= "f") nib = int'(c) - int'(8'h61) + 10;
        else if (c >= "A" && c <= "F") nib = int'(c) - int'(8'h41) + 10;
        lbl = STATUS_FRAME;
        bad = 1'b0;
        case (parser_state)
            P_START: begin
                if (nib < 0) begin
                    bad = 1'b1;
                end else begin
                    size_digits = 0;
                    chunk_left  = '0;
                    if (!absorb_digit(nib)) bad = 1'b1;
                    else parser_state = P_SIZE;
                end
            end
            P_SIZE: begin
                if (nib >= 0) begin
                    if (!absorb_digit(nib)) bad = 1'b1;
                end else if (c == CHAR_CR) begin
                    parser_state = P_SIZE_LF;
                end else if (c != CHAR_X_LOWER && c != CHAR_X_UPPER) begin
                    bad = 1'b1;
                end
            end
            P_SIZE_LF: begin
                if (c != CHAR_LF) begin
                    bad = 1'b1;
                end else begin
                    size_digits  = 0;
                    parser_state = (chunk_left == '0) ? P_END_CR : P_DATA;
                end
            end
            P_DATA: begin
                lbl = STATUS_PAYLOAD;
                if (chunk_left != '0) chunk_left = chunk_left - 1;
                if (chunk_left == '0) parser_state = P_DATA_CR;
            end
            P_DATA_CR: begin
                if (c != CHAR_CR) bad = 1'b1;
                else parser_state = P_DATA_LF;
            end
            P_DATA_LF: begin
                if (c != CHAR_LF) bad = 1'b1;
                else parser_state = P_START;
            end
            P_END_CR: begin
                if (c != CHAR_CR) bad = 1'b1;
                else parser_state = P_END_LF;
            end
            P_END_LF: begin
                if (c != CHAR_LF) begin
                    bad = 1'b1;
                end else begin
                    lbl          = STATUS_LAST;
                    parser_state = P_START;
                end
            end
            default: bad = 1'b1;
        endcase
        if (bad) begin
            parser_state = P_ERROR;
            lbl          = STATUS_ERROR;
        end
        return lbl;
    endfunction

    // Valid is only lowered when an idle gap is taken, so back-to-back
    // transactions keep it high across the handshake edge.
    task automatic send_byte(input logic [7:0] b);
        labeled_byte_t lb;
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid   <= 1'b1;
        s_data_in <= b;
        do @(posedge aclk); while (!s_ready);
        lb.data   = b;
        lb.status = predict_label(b);
        labeled_bytes.push_back(lb);
        bytes_sent++;
    endtask

    task automatic send_crlf();
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
    endtask

    // Size line with random letter case, optional leading zeros and stray
    // prefix markers anywhere after the first digit.
    task automatic send_size_line(input logic [31:0] size);
        int         ndig;
        int         lead;
        int         i;
        logic [3:0] nib;
        ndig = 1;
        while (ndig < SIZE_DIGITS_MAX && (size >> (4 * ndig)) != 0) ndig++;
        lead = ($urandom_range(3) == 0) ? $urandom_range(SIZE_DIGITS_MAX - ndig) : 0;
        for (i = 0; i < lead + ndig; i++) begin
            if (i > 0 && $urandom_range(7) == 0) begin
                send_byte($urandom_range(1) ? CHAR_X_LOWER : CHAR_X_UPPER);
            end
            nib = (i < lead) ? 4'd0 : size[4 * (lead + ndig - 1 - i) +: 4];
            if (nib < 4'd10) send_byte(8'h30 + 8'(nib));
            else send_byte(($urandom_range(1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10);
        end
        if ($urandom_range(15) == 0) begin
            send_byte($urandom_range(1) ? CHAR_X_LOWER : CHAR_X_UPPER);
        end
        send_crlf();
    endtask

    task automatic send_body(input int max_size);
        int n_chunks;
        int sz;
        n_chunks = $urandom_range(1, 4);
        repeat (n_chunks) begin
            sz = ($urandom_range(9) == 0) ? $urandom_range(1, max_size) : $urandom_range(1, 16);
            send_size_line(sz);
            repeat (sz) send_byte(8'($urandom_range(255)));
            send_crlf();
        end
        send_size_line(0);
        send_crlf();
    endtask

    task automatic test_directed();
        // One-byte chunk carrying the lowest byte value.
        send_byte("1");
        send_crlf();
        send_byte(8'h00);
        send_crlf();
        // Prefix marker after the first digit, size line at the digit limit,
        // and payload that holds the highest byte and a CR.
        send_byte("0");
        send_byte(CHAR_X_LOWER);
        repeat (SIZE_DIGITS_MAX - 2) send_byte("0");
        send_byte("2");
        send_crlf();
        send_byte(8'hFF);
        send_byte(CHAR_CR);
        send_crlf();
        // Zero-size line with an upper-case marker closes the body.
        send_byte("0");
        send_byte(CHAR_X_UPPER);
        send_crlf();
        send_crlf();
    endtask

    task automatic test_random_bodies(input int tx_pct, input int rx_pct, input int n_items);
        int start;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        start        = bytes_sent;
        while (bytes_sent - start < n_items) send_body(80);
    endtask

    task automatic test_backpressure();
        int start;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_request = 400;
        start        = bytes_sent;
        while (bytes_sent - start < 60) send_body(40);
    endtask

    // The error state is sticky, so this must be the last test of the run.
    task automatic test_sticky_error();
        int sz;
        tx_idle_pct  = 36;
        rx_stall_pct = 36;
        case ($urandom_range(2))
            0: begin
                // One digit more than the size line allows.
                repeat (SIZE_DIGITS_MAX) send_byte("0");
                send_byte("1");
            end
            1: begin
                // Chunk whose closing CR is replaced by a random byte.
                sz = $urandom_range(1, 8);
                send_size_line(sz);
                repeat (sz) send_byte(8'($urandom_range(255)));
                send_byte(8'($urandom_range(255)));
            end
            default: ;
        endcase
        repeat (60) send_byte(8'($urandom_range(255)));
    endtask

    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (labeled_bytes.size() == 0) begin
                $error("unexpected transaction: data_out %h, byte_status %0d",
                       m_data_out, m_byte_status);
                mismatches++;
            end else begin
                want = labeled_bytes.pop_front();
                if (m_data_out !== want.data) begin
                    $error("data_out: expected %h, actual %h", want.data, m_data_out);
                    mismatches++;
                end
                if (m_byte_status !== want.status) begin
                    $error("byte_status: expected %0d, actual %0d",
                           want.status, m_byte_status);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_bodies(0, 0, 90);
        test_random_bodies(82, 0, 90);
        test_random_bodies(0, 82, 90);
        test_random_bodies(36, 36, 90);
        test_backpressure();
        test_sticky_error();
        s_valid      <= 1'b0;
        rx_stall_pct = 0;
        while (labeled_bytes.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
